// File: hw/rtl/g2del_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and bundle types of the 2D grid edge list generator.
// No dependencies; every other file of the block imports this package.
package g2del_pkg;

  localparam int VERTEX_W     = 20;
  localparam int WEIGHT_W     = 32;
  localparam int SIDE_W       = 11;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int MAX_SIDE_DEF = 1024;

  localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT = 32'h0001_0000;
  localparam logic [SIDE_W-1:0]   SIDE_RESET  = 11'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VWEIGHT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIAG_EN  = 2'd3;

  // Clamped grid configuration plus a rewind strobe
  typedef struct packed {
    logic [SIDE_W-1:0]   height;
    logic [SIDE_W-1:0]   width;
    logic [WEIGHT_W-1:0] vweight;
    logic                diag;
    logic                rewind;
  } cfg_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] source_vertex;
    logic [VERTEX_W-1:0] target_vertex;
    logic [WEIGHT_W-1:0] edge_weight;
    logic                last_edge;
  } edge_t;

endpackage

// File: hw/rtl/g2del_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: edge requests in, edges out.
// Depends on g2del_pkg for the payload widths.
interface g2del_req_if;
  import g2del_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface g2del_edge_if;
  import g2del_pkg::*;
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] source_vertex;
  logic [VERTEX_W-1:0] target_vertex;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                last_edge;
  modport source (output valid, output source_vertex, output target_vertex,
                  output edge_weight, output last_edge, input ready);
  modport sink   (input valid, input source_vertex, input target_vertex,
                  input edge_weight, input last_edge, output ready);
endinterface

// File: hw/rtl/grid2d_edge_list_generator_top.sv
`timescale 1ns / 1ps
// Top level of the 2D grid edge list generator: config registers, walker, output register.
// Depends on g2del_pkg, g2del_if, g2del_cfg, g2del_walk and g2del_oreg.
//
// Each request beat on req yields one edge beat on edges in the next cycle, and a new request
// is taken every cycle while the sink takes edges: the walker's counters advance as the
// request is accepted and the edge lands in a single output register, so req.ready is high
// whenever that register is empty or being taken. Edges come row-major: vertical then
// horizontal edges for each row, the bottom row's horizontal edges, then (diagonal mode) the
// down-right diagonals; last_edge marks the final one and the list restarts. restart=1 emits
// the first edge. Writing height, width or diagonal mode rewinds to the first edge; writing
// the vertical weight does not. Sides are clamped to 2..MAX_SIDE when written.
module grid2d_edge_list_generator_top import g2del_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  g2del_req_if.sink              req,
  g2del_edge_if.source           edges
);

  cfg_t  cfg;
  edge_t res;
  logic  take;
  logic  fire;

  assign req.ready = take;
  assign fire      = req.valid && take;

  g2del_cfg #(
    .MAX_SIDE (MAX_SIDE)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  g2del_walk #(
    .MAX_SIDE (MAX_SIDE)
  ) u_walk (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .restart (req.restart),
    .res     (res)
  );

  g2del_oreg u_oreg (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .res   (res),
    .take  (take),
    .edges (edges)
  );

endmodule

// File: hw/rtl/g2del_cfg.sv
`timescale 1ns / 1ps
// Configuration registers: grid sides clamped at write time, vertical weight, diagonal mode.
// Depends on g2del_pkg.
module g2del_cfg import g2del_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  localparam int MW = $clog2(MAX_SIDE + 1);
  localparam int XW = (MW > SIDE_W) ? MW : SIDE_W;

  logic [SIDE_W-1:0]   height;
  logic [SIDE_W-1:0]   width;
  logic [WEIGHT_W-1:0] vweight;
  logic                diag;
  logic [SIDE_W-1:0]   side_raw;
  logic [SIDE_W-1:0]   side_clamped;

  // Clamp a side to 2..MAX_SIDE
  always_comb begin
    side_raw = wr_data[SIDE_W-1:0];
    if (side_raw < SIDE_RESET) begin
      side_clamped = SIDE_RESET;
    end else if (XW'(side_raw) > XW'(MAX_SIDE)) begin
      side_clamped = SIDE_W'(MAX_SIDE);
    end else begin
      side_clamped = side_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      height  <= SIDE_RESET;
      width   <= SIDE_RESET;
      vweight <= UNIT_WEIGHT;
      diag    <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEIGHT:  height  <= side_clamped;
        REG_WIDTH:   width   <= side_clamped;
        REG_VWEIGHT: vweight <= wr_data[WEIGHT_W-1:0];
        REG_DIAG_EN: diag    <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Shape changes send the walk back to the first edge
  always_comb begin
    cfg.height  = height;
    cfg.width   = width;
    cfg.vweight = vweight;
    cfg.diag    = diag;
    cfg.rewind  = wr_en && (wr_index == REG_HEIGHT || wr_index == REG_WIDTH ||
                            wr_index == REG_DIAG_EN);
  end

  a_side_min: assert property (@(posedge clk) disable iff (rst)
    height >= SIDE_RESET && width >= SIDE_RESET)
    else $error("grid side below two");

endmodule

// File: hw/rtl/g2del_walk.sv
`timescale 1ns / 1ps
// Edge walker: row/column position and phase, and the edge that the current position names.
// Depends on g2del_pkg.
module g2del_walk import g2del_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  fire,
  input  logic  restart,
  output edge_t res
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int XW = (CW > SIDE_W) ? CW : SIDE_W;

  typedef enum logic [1:0] {
    PH_VERT = 2'd0,
    PH_HORZ = 2'd1,
    PH_DIAG = 2'd2
  } phase_t;

  logic [CW-1:0]       row;
  logic [CW-1:0]       col;
  logic [VERTEX_W-1:0] row_base;
  phase_t              phase;

  logic [CW-1:0]       row_next;
  logic [CW-1:0]       col_next;
  logic [VERTEX_W-1:0] row_base_next;
  phase_t              phase_next;

  logic [CW-1:0]       cur_row;
  logic [CW-1:0]       cur_col;
  logic [VERTEX_W-1:0] cur_base;
  phase_t              cur_phase;
  logic [SIDE_W-1:0]   wm1;
  logic [SIDE_W-1:0]   wm2;
  logic [SIDE_W-1:0]   hm1;
  logic [SIDE_W-1:0]   hm2;
  logic [XW-1:0]       row_x;
  logic [XW-1:0]       col_x;
  logic [VERTEX_W-1:0] col_v;
  logic [VERTEX_W-1:0] base_down;
  logic                col_end_v;
  logic                col_end;

  always_comb begin
    cur_row   = restart ? '0 : row;
    cur_col   = restart ? '0 : col;
    cur_base  = restart ? '0 : row_base;
    cur_phase = restart ? PH_VERT : phase;

    wm1 = cfg.width - SIDE_W'(1);
    wm2 = cfg.width - SIDE_W'(2);
    hm1 = cfg.height - SIDE_W'(1);
    hm2 = cfg.height - SIDE_W'(2);

    row_x     = XW'(cur_row);
    col_x     = XW'(cur_col);
    col_v     = VERTEX_W'(cur_col);
    base_down = cur_base + VERTEX_W'(cfg.width);
    col_end_v = (col_x == XW'(wm1));
    col_end   = (col_x == XW'(wm2));

    row_next      = cur_row;
    col_next      = cur_col + CW'(1);
    row_base_next = cur_base;
    phase_next    = cur_phase;
    res.last_edge = 1'b0;

    case (cur_phase)
      PH_VERT: begin
        res.source_vertex = cur_base + col_v;
        res.target_vertex = base_down + col_v;
        res.edge_weight   = cfg.vweight;
        if (col_end_v) begin
          col_next   = '0;
          phase_next = PH_HORZ;
        end
      end
      PH_HORZ: begin
        res.source_vertex = cur_base + col_v;
        res.target_vertex = cur_base + col_v + VERTEX_W'(1);
        res.edge_weight   = UNIT_WEIGHT;
        if (col_end) begin
          col_next = '0;
          if (row_x == XW'(hm1)) begin
            row_next      = '0;
            row_base_next = '0;
            if (cfg.diag) begin
              phase_next = PH_DIAG;
            end else begin
              phase_next    = PH_VERT;
              res.last_edge = 1'b1;
            end
          end else begin
            row_next      = cur_row + CW'(1);
            row_base_next = base_down;
            // the row below the new one decides whether vertical edges remain
            phase_next    = (row_x + XW'(1) < XW'(hm1)) ? PH_VERT : PH_HORZ;
          end
        end
      end
      PH_DIAG: begin
        res.source_vertex = cur_base + col_v;
        res.target_vertex = base_down + col_v + VERTEX_W'(1);
        res.edge_weight   = UNIT_WEIGHT;
        if (col_end) begin
          col_next = '0;
          if (row_x == XW'(hm2)) begin
            row_next      = '0;
            row_base_next = '0;
            phase_next    = PH_VERT;
            res.last_edge = 1'b1;
          end else begin
            row_next      = cur_row + CW'(1);
            row_base_next = base_down;
          end
        end
      end
      default: begin
        res.source_vertex = '0;
        res.target_vertex = '0;
        res.edge_weight   = '0;
        row_next          = '0;
        col_next          = '0;
        row_base_next     = '0;
        phase_next        = PH_VERT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.rewind) begin
      row      <= '0;
      col      <= '0;
      row_base <= '0;
      phase    <= PH_VERT;
    end else if (fire) begin
      row      <= row_next;
      col      <= col_next;
      row_base <= row_base_next;
      phase    <= phase_next;
    end
  end

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    fire && res.last_edge |=> row == '0 && col == '0 && row_base == '0 && phase == PH_VERT)
    else $error("walk did not wrap after the last edge");

  a_base: assert property (@(posedge clk) disable iff (rst)
    row_base == VERTEX_W'(VERTEX_W'(row) * VERTEX_W'(cfg.width)))
    else $error("row base out of step with row counter");

  a_diag: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DIAG |-> cfg.diag)
    else $error("diagonal phase with diagonal mode off");

endmodule

// File: hw/rtl/g2del_oreg.sv
`timescale 1ns / 1ps
// Output register: holds one edge beat until the sink takes it.
// Depends on g2del_pkg and g2del_if.
module g2del_oreg import g2del_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  edge_t        res,
  output logic         take,
  g2del_edge_if.source edges
);

  logic  valid;
  edge_t data;

  // Free, or emptying this cycle
  assign take = !valid || edges.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= 1'b1;
    end else if (edges.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data <= res;
    end
  end

  assign edges.valid         = valid;
  assign edges.source_vertex = data.source_vertex;
  assign edges.target_vertex = data.target_vertex;
  assign edges.edge_weight   = data.edge_weight;
  assign edges.last_edge     = data.last_edge;

  a_load: assert property (@(posedge clk) disable iff (rst)
    fire |=> valid)
    else $error("accepted request produced no edge beat");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid && edges.ready && !fire |=> !valid)
    else $error("taken edge beat not dropped");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    fire |-> !valid || edges.ready)
    else $error("edge beat overwritten before taken");

endmodule
